// ----- hdl/tpc_pkg.sv -----
// Shared types and constants of the tilt position two-speed controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tpc_pkg;

   // fixed timing of the control loop, in ms
   localparam logic [31:0] DEBOUNCE_MS = 32'd20;
   localparam logic [31:0] MAX_STEP_MS = 32'd100;

   // field widths
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned TILT_W  = 24;
   localparam int unsigned LIM_W   = 23;
   localparam int unsigned SPEED_W = 13;
   localparam int unsigned RATE_W  = 8;
   localparam int unsigned MS_W    = 16;
   localparam int unsigned STEP_W  = 7;   // elapsed time of an advanced pass, at most 100

   // shared multiplier operand and product widths
   localparam int unsigned MUL_A_W = 20;  // holds STEP_W + SPEED_W
   localparam int unsigned MUL_B_W = 13;
   localparam int unsigned PROD_W  = 28;  // holds STEP_W + SPEED_W + RATE_W

   // configuration register indexes
   localparam logic [2:0] REG_TILT_LIMIT     = 3'd0;
   localparam logic [2:0] REG_POSITION_TOL   = 3'd1;
   localparam logic [2:0] REG_FAST_ERROR     = 3'd2;
   localparam logic [2:0] REG_SLOW_SPEED     = 3'd3;
   localparam logic [2:0] REG_FAST_SPEED     = 3'd4;
   localparam logic [2:0] REG_TILT_RATE      = 3'd5;
   localparam logic [2:0] REG_VISION_TIMEOUT = 3'd6;
   localparam logic [2:0] REG_RETRY_INTERVAL = 3'd7;

   // command kind codes
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_STOP = 2'd1;
   localparam logic [1:0] CMD_SET  = 2'd2;

   // configuration register file contents
   typedef struct packed {
      logic [LIM_W-1:0]   tilt_limit;
      logic [LIM_W-1:0]   position_tolerance;
      logic [LIM_W-1:0]   fast_error;
      logic [SPEED_W-1:0] slow_speed;
      logic [SPEED_W-1:0] fast_speed;
      logic [RATE_W-1:0]  tilt_rate;
      logic [MS_W-1:0]    vision_timeout;
      logic [MS_W-1:0]    retry_interval;
   } cfg_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRONT,
      ST_SCALE,
      ST_ADVANCE,
      ST_DECIDE
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/tpc_csr.sv -----
// Configuration register file of the tilt position controller.
// Depends on tpc_pkg for the register indexes and the cfg_type struct.
`default_nettype none

module tpc_csr (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [2:0]             csr_index,
   input  wire logic [22:0]            csr_wdata,
   output tpc_pkg::cfg_type            cfg
);
   import tpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // write decode, each register keeps its low bits of the data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TILT_LIMIT:     cfg_in.tilt_limit         = csr_wdata[LIM_W-1:0];
            REG_POSITION_TOL:   cfg_in.position_tolerance = csr_wdata[LIM_W-1:0];
            REG_FAST_ERROR:     cfg_in.fast_error         = csr_wdata[LIM_W-1:0];
            REG_SLOW_SPEED:     cfg_in.slow_speed         = csr_wdata[SPEED_W-1:0];
            REG_FAST_SPEED:     cfg_in.fast_speed         = csr_wdata[SPEED_W-1:0];
            REG_TILT_RATE:      cfg_in.tilt_rate          = csr_wdata[RATE_W-1:0];
            REG_VISION_TIMEOUT: cfg_in.vision_timeout     = csr_wdata[MS_W-1:0];
            REG_RETRY_INTERVAL: cfg_in.retry_interval     = csr_wdata[MS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tilt_limit         <= 23'd30000;
         cfg_ff.position_tolerance <= 23'd500;
         cfg_ff.fast_error         <= 23'd5000;
         cfg_ff.slow_speed         <= 13'd10;
         cfg_ff.fast_speed         <= 13'd60;
         cfg_ff.tilt_rate          <= 8'd6;
         cfg_ff.vision_timeout     <= 16'd300;
         cfg_ff.retry_interval     <= 16'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hdl/tpc_mul.sv -----
// Shared registered multiplier of the tilt position controller.
// Used twice per pass: elapsed time times speed, then that times tilt rate.
// Depends on tpc_pkg for operand and product widths.
`default_nettype none

module tpc_mul (
   input  wire logic                          clock,
   input  wire logic [tpc_pkg::MUL_A_W-1:0]   op_a,
   input  wire logic [tpc_pkg::MUL_B_W-1:0]   op_b,
   output logic      [tpc_pkg::PROD_W-1:0]    prod
);
   import tpc_pkg::*;

   logic [MUL_A_W+MUL_B_W-1:0] full_in;
   logic [PROD_W-1:0]          prod_ff;

   // both uses of the unit fit in PROD_W bits
   assign full_in = {{MUL_B_W{1'b0}}, op_a} * {{MUL_A_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= full_in[PROD_W-1:0];
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- hdl/tilt_position_two_speed_controller_unit.sv -----
// Tilt position two-speed controller: top level with sequencer and loop state.
// Steps: idle, front, speed scale, rate scale and advance, decide; decide loads the
// registered response. Requests are taken only in idle, so none is taken until the last
// is through; a stalled response holds the sequencer in its decide step. Reset is
// synchronous; loop state and control registers take their documented reset values
// at once, payload is not reset; a request is accepted in the first cycle after reset.
`default_nettype none

module tilt_position_two_speed_controller_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: now_ms[31:0], key_low[32], frame_valid[33], frame_target[57:34],
   // motor_accepts[58], zero fill above
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   // response data: command_direction[0], command_speed[13:1],
   // controller_reset[14], estimated_tilt[38:15], applied_target[62:39],
   // running[63], vision_ok[64], centering[65], zero fill above
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,
   // response user: command_kind[1:0]
   output logic [1:0]       rsp_tuser,
   // configuration write port
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [22:0] csr_wdata
);
   import tpc_pkg::*;

   cfg_type                cfg;
   state_type              state_ff, state_in;

   // latched request fields
   logic [TIME_W-1:0]      now_ff, now_in;
   logic                   key_ff, key_in;
   logic                   frame_ff, frame_in;
   logic [TILT_W-1:0]      ftarget_ff, ftarget_in;
   logic                   accepts_ff, accepts_in;

   // loop state
   logic                   key_timing_ff, key_timing_in;
   logic [TIME_W-1:0]      key_since_ff, key_since_in;
   logic                   center_ff, center_in;
   logic [TIME_W-1:0]      seen_at_ff, seen_at_in;
   logic                   live_ff, live_in;
   logic                   have_cmd_ff, have_cmd_in;
   logic [TILT_W-1:0]      held_ff, held_in;
   logic                   motor_on_ff, motor_on_in;
   logic                   motor_dir_ff, motor_dir_in;
   logic [SPEED_W-1:0]     rpm_ff, rpm_in;
   logic [TILT_W-1:0]      est_ff, est_in;
   logic [TIME_W-1:0]      attempt_at_ff, attempt_at_in;
   logic [TIME_W-1:0]      motion_at_ff, motion_at_in;

   // per-pass working registers
   logic                   pulse_ff, pulse_in;
   logic                   adv_ff, adv_in;
   logic [TILT_W-1:0]      target_ff, target_in;

   // response registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [71:0]            rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;

   // shared multiplier
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [PROD_W-1:0]      prod;

   // front-end arithmetic
   logic [TIME_W-1:0]      key_age;
   logic                   live_n;
   logic [TIME_W-1:0]      seen_n;
   logic [TIME_W-1:0]      vis_age;
   logic [TIME_W-1:0]      elapsed;

   // advance arithmetic
   logic signed [29:0]     est_ext, d_ext, lim30, tsum, tclamp;
   logic signed [24:0]     traw, lim25, tclamp25;

   // decision arithmetic
   logic signed [25:0]     err26, tol26, fast26;
   logic                   in_band, is_fast, rdir, retry_ok, go;
   logic [SPEED_W-1:0]     rspeed;
   logic [1:0]             kind;
   logic                   cdir;
   logic [SPEED_W-1:0]     cspeed;
   logic [TIME_W-1:0]      retry_age;

   tpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // datapath terms used by the sequencer
   assign key_age   = now_ff - key_since_ff;
   assign live_n    = frame_ff | live_ff;
   assign seen_n    = frame_ff ? now_ff : seen_at_ff;
   assign vis_age   = now_ff - seen_n;
   assign elapsed   = now_ff - motion_at_ff;

   assign est_ext   = $signed({{6{est_ff[TILT_W-1]}}, est_ff});
   assign d_ext     = $signed({2'b00, prod});
   assign lim30     = $signed({7'd0, cfg.tilt_limit});
   assign tsum      = motor_dir_ff ? (est_ext - d_ext) : (est_ext + d_ext);

   assign traw      = (!live_ff || !have_cmd_ff || center_ff) ? 25'sd0 :
                      $signed({held_ff[TILT_W-1], held_ff});
   assign lim25     = $signed({2'b00, cfg.tilt_limit});

   assign err26     = $signed({{2{target_ff[TILT_W-1]}}, target_ff})
                    - $signed({{2{est_ff[TILT_W-1]}}, est_ff});
   assign tol26     = $signed({3'b000, cfg.position_tolerance});
   assign fast26    = $signed({3'b000, cfg.fast_error});
   assign retry_age = now_ff - attempt_at_ff;

   // clamp of the advanced estimate and of the target
   always_comb begin
      if (tsum > lim30) begin
         tclamp = lim30;
      end else if (tsum < -lim30) begin
         tclamp = -lim30;
      end else begin
         tclamp = tsum;
      end
      if (traw > lim25) begin
         tclamp25 = lim25;
      end else if (traw < -lim25) begin
         tclamp25 = -lim25;
      end else begin
         tclamp25 = traw;
      end
   end

   // decision terms
   always_comb begin
      in_band  = (err26 <= tol26) && (err26 >= -tol26);
      is_fast  = (err26 >= fast26) || (err26 <= -fast26);
      rdir     = !(err26 > 26'sd0);
      rspeed   = is_fast ? cfg.fast_speed : cfg.slow_speed;
      retry_ok = retry_age >= {16'd0, cfg.retry_interval};
      go       = !rsp_valid_ff || rsp_tready;
   end

   // sequencer: next state, loop state updates, multiplier operands
   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      key_in        = key_ff;
      frame_in      = frame_ff;
      ftarget_in    = ftarget_ff;
      accepts_in    = accepts_ff;
      key_timing_in = key_timing_ff;
      key_since_in  = key_since_ff;
      center_in     = center_ff;
      seen_at_in    = seen_at_ff;
      live_in       = live_ff;
      have_cmd_in   = have_cmd_ff;
      held_in       = held_ff;
      motor_on_in   = motor_on_ff;
      motor_dir_in  = motor_dir_ff;
      rpm_in        = rpm_ff;
      est_in        = est_ff;
      attempt_at_in = attempt_at_ff;
      motion_at_in  = motion_at_ff;
      pulse_in      = pulse_ff;
      adv_in        = adv_ff;
      target_in     = target_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mul_a         = '0;
      mul_b         = '0;
      kind          = CMD_NONE;
      cdir          = 1'b0;
      cspeed        = '0;
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               now_in     = req_tdata[31:0];
               key_in     = req_tdata[32];
               frame_in   = req_tdata[33];
               ftarget_in = req_tdata[57:34];
               accepts_in = req_tdata[58];
               state_in   = ST_FRONT;
            end
         end

         // key debounce, vision update and timeout, start of dead reckoning
         ST_FRONT: begin
            pulse_in = 1'b0;
            if (key_ff) begin
               if (!key_timing_ff) begin
                  key_timing_in = 1'b1;
                  key_since_in  = now_ff;
               end else if (key_age >= DEBOUNCE_MS) begin
                  if (!center_ff) pulse_in = 1'b1;
                  center_in = 1'b1;
               end
            end else begin
               key_timing_in = 1'b0;
               center_in     = 1'b0;
            end

            seen_at_in = seen_n;
            live_in    = live_n;
            if (frame_ff) begin
               held_in     = ftarget_ff;
               have_cmd_in = 1'b1;
            end
            if (live_n && (vis_age >= {16'd0, cfg.vision_timeout})) begin
               live_in     = 1'b0;
               have_cmd_in = 1'b0;
               pulse_in    = 1'b1;
               held_in     = '0;
            end

            motion_at_in = now_ff;
            adv_in       = motor_on_ff && (elapsed <= MAX_STEP_MS);
            mul_a        = {{(MUL_A_W-STEP_W){1'b0}}, elapsed[STEP_W-1:0]};
            mul_b        = rpm_ff;
            state_in     = ST_SCALE;
         end

         // elapsed times speed is in the product; scale by tilt rate
         ST_SCALE: begin
            mul_a    = prod[MUL_A_W-1:0];
            mul_b    = {{(MUL_B_W-RATE_W){1'b0}}, cfg.tilt_rate};
            state_in = ST_ADVANCE;
         end

         // advance and clamp the estimate, clamp the target
         ST_ADVANCE: begin
            if (adv_ff) est_in = tclamp[TILT_W-1:0];
            target_in = tclamp25[TILT_W-1:0];
            state_in  = ST_DECIDE;
         end

         // stop or speed command, then load the response
         ST_DECIDE: begin
            if (in_band) begin
               if (motor_on_ff && retry_ok) begin
                  kind = CMD_STOP;
                  if (accepts_ff) begin
                     motor_on_in = 1'b0;
                     rpm_in      = '0;
                     est_in      = target_ff;
                  end
               end
            end else if ((!motor_on_ff || motor_dir_ff != rdir || rpm_ff != rspeed)
                         && retry_ok) begin
               kind   = CMD_SET;
               cdir   = rdir;
               cspeed = rspeed;
               if (accepts_ff) begin
                  motor_on_in  = 1'b1;
                  motor_dir_in = rdir;
                  rpm_in       = rspeed;
                  motion_at_in = now_ff;
               end
            end
            if (kind != CMD_NONE) attempt_at_in = now_ff;

            if (go) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind;
               rsp_data_in  = {6'd0, center_ff, live_ff, motor_on_in, target_ff,
                               est_in, pulse_ff, cspeed, cdir};
               state_in     = ST_IDLE;
            end else begin
               // hold all loop state until the response slot frees up
               motor_on_in   = motor_on_ff;
               motor_dir_in  = motor_dir_ff;
               rpm_in        = rpm_ff;
               est_in        = est_ff;
               motion_at_in  = motion_at_ff;
               attempt_at_in = attempt_at_ff;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and loop state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         key_timing_ff <= 1'b0;
         key_since_ff  <= '0;
         center_ff     <= 1'b0;
         seen_at_ff    <= '0;
         live_ff       <= 1'b0;
         have_cmd_ff   <= 1'b0;
         held_ff       <= '0;
         motor_on_ff   <= 1'b0;
         motor_dir_ff  <= 1'b0;
         rpm_ff        <= '0;
         est_ff        <= '0;
         attempt_at_ff <= '0;
         motion_at_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         key_timing_ff <= key_timing_in;
         key_since_ff  <= key_since_in;
         center_ff     <= center_in;
         seen_at_ff    <= seen_at_in;
         live_ff       <= live_in;
         have_cmd_ff   <= have_cmd_in;
         held_ff       <= held_in;
         motor_on_ff   <= motor_on_in;
         motor_dir_ff  <= motor_dir_in;
         rpm_ff        <= rpm_in;
         est_ff        <= est_in;
         attempt_at_ff <= attempt_at_in;
         motion_at_ff  <= motion_at_in;
      end
   end

   // payload and per-pass working registers
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      key_ff      <= key_in;
      frame_ff    <= frame_in;
      ftarget_ff  <= ftarget_in;
      accepts_ff  <= accepts_in;
      pulse_ff    <= pulse_in;
      adv_ff      <= adv_in;
      target_ff   <= target_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

`default_nettype wire
